FILE: hdl/pfs_pkg.sv
package pfs_pkg;

  localparam int unsigned FB_WORDS_DEF = 65536;
  localparam int unsigned PAL_ENTRIES  = 256;
  localparam int unsigned PAL_AW       = 8;

  localparam int unsigned OP_W       = 2;
  localparam int unsigned ADDR_W     = 24;
  localparam int unsigned WIDX_W     = 22;
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned DIM_W      = 12;
  localparam int unsigned OFS_W      = 18;
  localparam int unsigned SKIP_W     = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;
  // Scan word counter: start word plus up to 4095 lines of up to 4095 words
  localparam int unsigned SCAN_AW    = 25;

  localparam logic [3:0] REGION_CTRL = 4'hF;
  localparam logic [3:0] REGION_PAL  = 4'hE;

  localparam int unsigned SKIP_HALVE_W = 0;
  localparam int unsigned SKIP_HALVE_H = 1;

  localparam logic [DIM_W-1:0] WIDTH_RST  = 12'd640;
  localparam logic [DIM_W-1:0] HEIGHT_RST = 12'd480;

  localparam logic KIND_READ  = 1'b0;
  localparam logic KIND_PIXEL = 1'b1;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_SCAN  = 2'd2
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCAN_START   = 2'd0,
    REG_FRAME_WIDTH  = 2'd1,
    REG_FRAME_HEIGHT = 2'd2,
    REG_SKIP_MODE    = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic bus_write;
    logic bus_read;
    logic scan_adjust;
    logic clr_step;
    logic fb_fetch;
    logic pal_first;
    logic pal_next;
    logic load_read;
    logic load_pix;
    logic scan_finish;
  } cmd_t;

  typedef struct packed {
    logic op_write;
    logic op_read;
    logic op_scan;
    logic geom_empty;
    logic clr_last;
    logic slot_free;
    logic last_pix;
  } sts_t;

  function automatic logic [WORD_W-1:0] byte_swap(input logic [WORD_W-1:0] v);
    return {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

endpackage

FILE: hdl/pfs_if.sv
interface pfs_req_if;
  import pfs_pkg::*;
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     operation;
  logic [ADDR_W-1:0]   address;
  logic [WORD_W-1:0]   write_data;

  modport source (output valid, output operation, output address, output write_data,
                  input ready);
  modport sink   (input valid, input operation, input address, input write_data,
                  output ready);
endinterface

interface pfs_rsp_if;
  import pfs_pkg::*;
  logic                valid;
  logic                ready;
  logic                kind;
  logic [WORD_W-1:0]   data;
  logic                end_of_row;
  logic                end_of_frame;
  logic                last;

  modport source (output valid, output kind, output data, output end_of_row,
                  output end_of_frame, output last, input ready);
  modport sink   (input valid, input kind, input data, input end_of_row,
                  input end_of_frame, input last, output ready);
endinterface

interface pfs_cfg_if;
  import pfs_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hdl/pfs_ram.sv
module pfs_ram #(
  parameter int unsigned WIDTH = pfs_pkg::WORD_W,
  parameter int unsigned DEPTH = pfs_pkg::PAL_ENTRIES
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hdl/pfs_ctrl.sv
module pfs_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  pfs_pkg::sts_t sts,
  output pfs_pkg::cmd_t cmd
);
  import pfs_pkg::*;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_READ  = 6'b000100,
    S_FETCH = 6'b001000,
    S_PAL   = 6'b010000,
    S_EMIT  = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    req_ready  = 1'b0;
    state_next = state;
    case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          if (sts.op_write) begin
            cmd.bus_write = 1'b1;
          end else if (sts.op_read) begin
            cmd.bus_read = 1'b1;
            state_next   = S_READ;
          end else if (sts.op_scan && !sts.geom_empty) begin
            cmd.scan_adjust = 1'b1;
            state_next      = S_FETCH;
          end
        end
      end
      S_READ: begin
        if (sts.slot_free) begin
          cmd.load_read = 1'b1;
          state_next    = S_IDLE;
        end
      end
      S_FETCH: begin
        cmd.fb_fetch = 1'b1;
        state_next   = S_PAL;
      end
      S_PAL: begin
        cmd.pal_first = 1'b1;
        state_next    = S_EMIT;
      end
      S_EMIT: begin
        if (sts.slot_free) begin
          cmd.load_pix = 1'b1;
          if (sts.last_pix) begin
            cmd.scan_finish = 1'b1;
            state_next      = S_IDLE;
          end else begin
            cmd.pal_next = 1'b1;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // the clearing pass runs once per reset
  a_clear_once: assert property (@(posedge clk) disable iff (rst)
    state != S_CLEAR |=> state != S_CLEAR)
    else $error("clearing pass re-entered without reset");

  a_finish_frees: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_finish |=> req_ready)
    else $error("input not taken after the last pixel of a scan step");

endmodule

FILE: hdl/pfs_dp.sv
module pfs_dp #(
  parameter int unsigned FB_WORDS = pfs_pkg::FB_WORDS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  pfs_pkg::cmd_t                   cmd,
  output pfs_pkg::sts_t                   sts,
  input  logic [pfs_pkg::OP_W-1:0]        operation,
  input  logic [pfs_pkg::ADDR_W-1:0]      address,
  input  logic [pfs_pkg::WORD_W-1:0]      write_data,
  input  logic                            cfg_valid,
  input  logic [pfs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pfs_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_kind,
  output logic [pfs_pkg::WORD_W-1:0]      out_data,
  output logic                            out_eor,
  output logic                            out_eof,
  output logic                            out_last
);
  import pfs_pkg::*;

  localparam int unsigned FB_AW = (FB_WORDS > 1) ? $clog2(FB_WORDS) : 1;

  // configuration
  logic [OFS_W-1:0]  start_off;
  logic [DIM_W-1:0]  fwidth;
  logic [DIM_W-1:0]  fheight;
  logic [SKIP_W-1:0] skip_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_off <= '0;
      fwidth    <= WIDTH_RST;
      fheight   <= HEIGHT_RST;
      skip_mode <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SCAN_START:   start_off <= cfg_data[OFS_W-1:0];
        REG_FRAME_WIDTH:  fwidth    <= cfg_data[DIM_W-1:0];
        REG_FRAME_HEIGHT: fheight   <= cfg_data[DIM_W-1:0];
        REG_SKIP_MODE:    skip_mode <= cfg_data[SKIP_W-1:0];
        default: ;
      endcase
    end
  end

  logic [DIM_W-1:0] w;
  logic [DIM_W-1:0] h;
  assign w = skip_mode[SKIP_HALVE_W] ? {1'b0, fwidth[DIM_W-1:1]} : fwidth;
  assign h = skip_mode[SKIP_HALVE_H] ? {1'b0, fheight[DIM_W-1:1]} : fheight;

  // bus decode
  logic [WIDX_W-1:0] widx;
  logic [3:0]        region;
  logic              widx_ok;
  assign widx    = address[ADDR_W-1:2];
  assign region  = address[ADDR_W-1:ADDR_W-4];
  assign widx_ok = 32'(widx) < FB_WORDS;

  // scan position
  logic [SCAN_AW-1:0] saddr;
  logic [DIM_W-1:0]   col;
  logic [DIM_W-1:0]   line;
  logic [SCAN_AW-1:0] restart_addr;
  logic [SCAN_AW-1:0] adj_addr;
  logic [DIM_W-1:0]   adj_col;
  logic [DIM_W-1:0]   adj_line;
  logic [SCAN_AW-1:0] fin_addr;
  logic [DIM_W-1:0]   fin_col;
  logic [DIM_W-1:0]   fin_line;
  logic [DIM_W-1:0]   col_sum;
  logic [2:0]         n_pix;
  logic [1:0]         k;
  logic               oor_scan;
  logic               rd_oor;

  assign restart_addr = SCAN_AW'(start_off[OFS_W-1:2]);

  // line or frame wrap left pending by a geometry change
  always_comb begin
    adj_addr = saddr;
    adj_col  = col;
    adj_line = line;
    if (line >= h) begin
      adj_addr = restart_addr;
      adj_col  = '0;
      adj_line = '0;
    end
    if (adj_col >= w) begin
      adj_col  = '0;
      adj_line = adj_line + 1'b1;
      if (adj_line >= h) begin
        adj_line = '0;
        adj_addr = restart_addr;
      end
    end
  end

  assign col_sum = col + DIM_W'(n_pix);

  always_comb begin
    fin_addr = saddr + 1'b1;
    fin_col  = col_sum;
    fin_line = line;
    if (col_sum >= w) begin
      fin_col  = '0;
      fin_line = line + 1'b1;
      if (fin_line >= h) begin
        fin_line = '0;
        fin_addr = restart_addr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      saddr <= '0;
      col   <= '0;
      line  <= '0;
    end else if (cmd.scan_adjust) begin
      saddr <= adj_addr;
      col   <= adj_col;
      line  <= adj_line;
    end else if (cmd.scan_finish) begin
      saddr <= fin_addr;
      col   <= fin_col;
      line  <= fin_line;
    end
  end

  logic [DIM_W-1:0] rem;
  assign rem = w - col;

  always_ff @(posedge clk) begin
    if (cmd.fb_fetch) begin
      n_pix    <= (rem > DIM_W'(4)) ? 3'd4 : rem[2:0];
      oor_scan <= !(32'(saddr) < FB_WORDS);
    end
    if (cmd.bus_read) begin
      rd_oor <= !widx_ok;
    end
    if (cmd.pal_first) begin
      k <= '0;
    end else if (cmd.pal_next) begin
      k <= k + 2'd1;
    end
  end

  // framebuffer, zeroed by a sweep after reset
  logic [FB_AW-1:0]  clr_addr;
  logic              fb_we;
  logic [FB_AW-1:0]  fb_waddr;
  logic [WORD_W-1:0] fb_wdata;
  logic              fb_re;
  logic [FB_AW-1:0]  fb_raddr;
  logic [WORD_W-1:0] fb_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr_step) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  assign fb_we    = cmd.clr_step ||
                    (cmd.bus_write && region != REGION_CTRL && region != REGION_PAL && widx_ok);
  assign fb_waddr = cmd.clr_step ? clr_addr : widx[FB_AW-1:0];
  assign fb_wdata = cmd.clr_step ? '0 : write_data;
  assign fb_re    = cmd.bus_read || cmd.fb_fetch;
  assign fb_raddr = cmd.bus_read ? widx[FB_AW-1:0] : saddr[FB_AW-1:0];

  pfs_ram #(
    .WIDTH(WORD_W),
    .DEPTH(FB_WORDS)
  ) u_fb_ram (
    .clk  (clk),
    .we   (fb_we),
    .waddr(fb_waddr),
    .wdata(fb_wdata),
    .re   (fb_re),
    .raddr(fb_raddr),
    .rdata(fb_rdata)
  );

  // palette; an entry never written reads as zero
  logic [PAL_ENTRIES-1:0] pal_vld;
  logic                   pal_we;
  logic                   pal_re;
  logic [1:0]             pal_sel;
  logic [WORD_W-1:0]      scan_word;
  logic [PAL_AW-1:0]      pix;
  logic [WORD_W-1:0]      pal_rdata;
  logic                   pal_ok;

  assign pal_we    = cmd.bus_write && region == REGION_PAL;
  assign pal_re    = cmd.pal_first || cmd.pal_next;
  assign pal_sel   = cmd.pal_first ? 2'd0 : k + 2'd1;
  assign scan_word = oor_scan ? '0 : fb_rdata;
  assign pix       = scan_word[8*pal_sel +: 8];

  always_ff @(posedge clk) begin
    if (rst) begin
      pal_vld <= '0;
    end else if (pal_we) begin
      pal_vld[widx[PAL_AW-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pal_re) begin
      pal_ok <= pal_vld[pix];
    end
  end

  pfs_ram #(
    .WIDTH(WORD_W),
    .DEPTH(PAL_ENTRIES)
  ) u_pal_ram (
    .clk  (clk),
    .we   (pal_we),
    .waddr(widx[PAL_AW-1:0]),
    .wdata(byte_swap(write_data)),
    .re   (pal_re),
    .raddr(pix),
    .rdata(pal_rdata)
  );

  // pixel markers
  logic [DIM_W-1:0] pcol;
  logic             eor;
  logic             eof;
  logic             last_pix;
  assign pcol     = col + DIM_W'(k);
  assign eor      = pcol == (w - 1'b1);
  assign eof      = eor && (line == (h - 1'b1));
  assign last_pix = {1'b0, k} == (n_pix - 3'd1);

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_read || cmd.load_pix) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_read) begin
      out_kind <= KIND_READ;
      out_data <= rd_oor ? '0 : fb_rdata;
      out_eor  <= 1'b0;
      out_eof  <= 1'b0;
      out_last <= 1'b1;
    end else if (cmd.load_pix) begin
      out_kind <= KIND_PIXEL;
      out_data <= pal_ok ? pal_rdata : '0;
      out_eor  <= eor;
      out_eof  <= eof;
      out_last <= last_pix;
    end
  end

  always_comb begin
    sts            = '0;
    sts.op_write   = operation == OP_WRITE;
    sts.op_read    = operation == OP_READ;
    sts.op_scan    = operation == OP_SCAN;
    sts.geom_empty = (w == '0) || (h == '0);
    sts.clr_last   = clr_addr == FB_AW'(FB_WORDS - 1);
    sts.slot_free  = !out_valid || out_ready;
    sts.last_pix   = last_pix;
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.load_read || cmd.load_pix) |-> (!out_valid || out_ready))
    else $error("output word overwritten before it was taken");

  a_fb_port: assert property (@(posedge clk) disable iff (rst)
    !(fb_we && fb_re))
    else $error("framebuffer written and read in the same cycle");

  a_pix_count: assert property (@(posedge clk) disable iff (rst)
    cmd.load_pix |-> ({1'b0, k} < n_pix))
    else $error("pixel emitted beyond the count of the scan step");

endmodule

FILE: hdl/palette_framebuffer_scanout_unit.sv
// Indexed-color scanout: a word framebuffer of FB_WORDS entries and a 256-entry
// palette, served through one request channel (bus write, bus read, scan step)
// and one result channel. A bus write yields no word. A bus read yields its
// word through the framebuffer's registered read and the output register, and
// waits while the result slot is full. A scan step yields n pixels (n up to
// four), in order: accept and settle the line and frame wrap, read the
// framebuffer, start the palette read, then one pixel per cycle from the
// palette port while the result side takes them; stalls there hold it back.
// After reset the framebuffer is zeroed by a sweep over all FB_WORDS words
// during which no request is taken; register writes are taken at any time.
module palette_framebuffer_scanout_unit #(
  parameter int unsigned FB_WORDS = pfs_pkg::FB_WORDS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  pfs_req_if.sink   req,
  pfs_rsp_if.source rsp,
  pfs_cfg_if.sink   cfg
);
  import pfs_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg.ready = 1'b1;

  pfs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req.valid),
    .req_ready(req.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pfs_dp #(
    .FB_WORDS(FB_WORDS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .operation (req.operation),
    .address   (req.address),
    .write_data(req.write_data),
    .cfg_valid (cfg.valid),
    .cfg_index (cfg.index),
    .cfg_data  (cfg.data),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .out_kind  (rsp.kind),
    .out_data  (rsp.data),
    .out_eor   (rsp.end_of_row),
    .out_eof   (rsp.end_of_frame),
    .out_last  (rsp.last)
  );

endmodule
